FILE: hdl/assert_macros.svh
// Assertion macros for the capture block's RTL; included by lfc_core.
// Each macro expects signals named clk and rst in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define LFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define LFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lfc_pkg.sv
// Types and fixed constants for the LCD field capture block.
// No dependencies; imported by every module of the block.
package lfc_pkg;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  localparam int unsigned LAST_WRITTEN_FIELD_LIMIT = 2;
  localparam logic [2:0]  FIELD_MAX  = 3'd7;
  localparam logic [7:0]  COUNT_MAX  = 8'd255;
  localparam logic [8:0]  COLUMN_STEP = 9'd4;

  typedef struct packed {
    op_t        op;
    logic       pixel_clock;
    logic       line_latch;
    logic       frame_polarity;
    logic [3:0] pixel_nibble;
  } sample_t;

  typedef struct packed {
    logic       write_valid;
    logic       write_field;
    logic [7:0] write_row;
    logic [7:0] write_column;
    logic [3:0] write_pixels;
    logic       frame_done;
  } result_t;

endpackage

FILE: hdl/lfc_core.sv
// Capture state and per-sample decode: edge detection, field/row/column counters.
// Depends on lfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfc_core #(
  parameter int FRAME_WIDTH  = 160,
  parameter int FRAME_HEIGHT = 144,
  parameter int SKIP_PERIOD  = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  lfc_pkg::sample_t sample,
  output logic             result_present,
  output lfc_pkg::result_t result
);
  import lfc_pkg::*;

  localparam int         ROW_MOD_W = (SKIP_PERIOD > 1) ? $clog2(SKIP_PERIOD) : 1;
  localparam logic [8:0] COL_LIMIT = 9'(FRAME_WIDTH - 3);
  localparam logic [8:0] ROW_LIMIT = 9'(FRAME_HEIGHT);
  localparam logic [ROW_MOD_W-1:0] ROW_MOD_LAST = ROW_MOD_W'(SKIP_PERIOD - 1);
  localparam logic [ROW_MOD_W-1:0] ROW_MOD_ONE  = ROW_MOD_W'(1);

  logic                 waiting, waiting_next;
  logic                 prev_clk, prev_clk_next;
  logic                 prev_lat, prev_lat_next;
  logic                 prev_pol, prev_pol_next;
  logic [2:0]           field, field_next;
  logic [7:0]           row, row_next;
  logic [ROW_MOD_W-1:0] row_mod, row_mod_next;
  logic [7:0]           column, column_next;
  logic                 skipping, skipping_next;
  logic                 finished, finished_next;

  logic       lat_rise, clk_rise, proceed, write_ok;
  logic [8:0] column_sum;
  logic [2:0] field_inc;

  always_comb begin
    waiting_next   = waiting;
    prev_clk_next  = prev_clk;
    prev_lat_next  = prev_lat;
    prev_pol_next  = prev_pol;
    field_next     = field;
    row_next       = row;
    row_mod_next   = row_mod;
    column_next    = column;
    skipping_next  = skipping;
    finished_next  = finished;
    result         = '0;
    result_present = 1'b0;

    lat_rise   = sample.line_latch && !prev_lat;
    clk_rise   = sample.pixel_clock && !prev_clk && !lat_rise;
    proceed    = !waiting || (!prev_pol && sample.frame_polarity);
    write_ok   = ({1'b0, column} < COL_LIMIT) && !skipping && ({1'b0, row} < ROW_LIMIT)
                 && (32'(field) < LAST_WRITTEN_FIELD_LIMIT);
    column_sum = {1'b0, column} + COLUMN_STEP;
    field_inc  = (field == FIELD_MAX) ? FIELD_MAX : field + 3'd1;

    unique case (sample.op)
      OP_RESTART: begin
        waiting_next  = 1'b1;
        prev_clk_next = 1'b0;
        prev_lat_next = 1'b0;
        prev_pol_next = 1'b1;
        field_next    = '0;
        row_next      = '0;
        row_mod_next  = '0;
        column_next   = '0;
        skipping_next = 1'b0;
        finished_next = 1'b0;
      end
      OP_SAMPLE: begin
        if (!finished) begin
          prev_clk_next = sample.pixel_clock;
          prev_lat_next = sample.line_latch;
          prev_pol_next = sample.frame_polarity;
          if (proceed) begin
            waiting_next = 1'b0;
            if (lat_rise) begin
              // swallow one spare latch at each multiple of the skip period
              if (row_mod == '0 && !skipping) begin
                skipping_next = 1'b1;
              end else begin
                skipping_next = 1'b0;
                column_next   = '0;
                if (row != COUNT_MAX) begin
                  row_next     = row + 8'd1;
                  row_mod_next = (row_mod == ROW_MOD_LAST) ? '0 : row_mod + ROW_MOD_ONE;
                end
              end
            end else if (clk_rise && write_ok) begin
              result.write_valid  = 1'b1;
              result.write_field  = field[0];
              result.write_row    = row;
              result.write_column = column;
              result.write_pixels = sample.pixel_nibble;
              result_present      = 1'b1;
              column_next = column_sum[8] ? COUNT_MAX : column_sum[7:0];
            end
            // waiting always ends with polarity high, so no edge is seen here then
            if (waiting ? 1'b0 : (sample.frame_polarity != prev_pol)) begin
              field_next   = field_inc;
              row_next     = '0;
              row_mod_next = '0;
              column_next  = '0;
              if (sample.frame_polarity && 32'(field_inc) > LAST_WRITTEN_FIELD_LIMIT) begin
                finished_next     = 1'b1;
                result            = '0;
                result.frame_done = 1'b1;
                result_present    = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    result_present = result_present && advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting  <= 1'b1;
      prev_clk <= 1'b0;
      prev_lat <= 1'b0;
      prev_pol <= 1'b1;
      field    <= '0;
      row      <= '0;
      row_mod  <= '0;
      column   <= '0;
      skipping <= 1'b0;
      finished <= 1'b0;
    end else if (advance) begin
      waiting  <= waiting_next;
      prev_clk <= prev_clk_next;
      prev_lat <= prev_lat_next;
      prev_pol <= prev_pol_next;
      field    <= field_next;
      row      <= row_next;
      row_mod  <= row_mod_next;
      column   <= column_next;
      skipping <= skipping_next;
      finished <= finished_next;
    end
  end

  `LFC_ASSERT_IMPL(a_write_or_done, result_present,
                   result.write_valid != result.frame_done, "result is neither write nor done")
  `LFC_ASSERT_IMPL(a_write_in_range, result_present && result.write_valid,
                   result.write_column[1:0] == 2'b00 && ({1'b0, result.write_row} < ROW_LIMIT),
                   "write outside the frame")
  `LFC_ASSERT_NEXT(a_finished_sticky, finished && !(advance && sample.op == OP_RESTART),
                   finished, "capture finished flag dropped without restart")

endmodule

FILE: hdl/lfc_out_reg.sv
// Result register between the capture decode and the result channel.
// Depends on lfc_pkg.
module lfc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             load_present,
  input  lfc_pkg::result_t load_data,
  output logic             free,
  output logic             result_valid,
  input  logic             result_ready,
  output lfc_pkg::result_t result_data
);
  import lfc_pkg::*;

  assign free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= load_present;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // hold payload while stalled; take a new one only when something is produced
  always_ff @(posedge clk) begin
    if (load && load_present) begin
      result_data <= load_data;
    end
  end

endmodule

FILE: hdl/lcd_field_capture.sv
// LCD field capture block, top level: sample register, decode core, result register.
// Depends on lfc_pkg, lfc_core and lfc_out_reg.
//
// Usage: one sample of the LCD bus pins (or a restart) enters on the sample
// channel per transaction (sample_valid/sample_ready). Each sample yields zero
// or one transaction on the result channel (result_valid/result_ready): a
// framebuffer write of four pixels, or a frame-done marker.
// A sample accepted on the sample channel waits in the sample register and is decoded
// there; its result, if any, is loaded into the result register (result_valid rises) once free.
// Throughput: one sample per cycle while the receiver does not stall, set by the
// combinational decode between the sample register and the result register; the
// capture counters update in the same cycle as the result register loads.
// Reset (rst, synchronous) clears both registers and rearms the capture: it
// waits for a rising frame polarity edge, as after a restart transaction.
// When the receiver stalls, the result register holds its transaction and
// the sample register still takes one more sample; sample_ready then drops
// until the result is taken. No result is ever dropped or repeated.
module lcd_field_capture #(
  parameter int FRAME_WIDTH  = 160,
  parameter int FRAME_HEIGHT = 144,
  parameter int SKIP_PERIOD  = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       sample_valid,
  output logic       sample_ready,
  input  logic       operation,
  input  logic       pixel_clock,
  input  logic       line_latch,
  input  logic       frame_polarity,
  input  logic [3:0] pixel_nibble,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       write_valid,
  output logic       write_field,
  output logic [7:0] write_row,
  output logic [7:0] write_column,
  output logic [3:0] write_pixels,
  output logic       frame_done
);
  import lfc_pkg::*;

  logic    stage_valid;
  sample_t stage;
  logic    out_free;
  logic    advance;
  logic    core_present;
  result_t core_result;
  result_t out_data;

  assign advance      = stage_valid && out_free;
  assign sample_ready = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage.op             <= op_t'(operation);
      stage.pixel_clock    <= pixel_clock;
      stage.line_latch     <= line_latch;
      stage.frame_polarity <= frame_polarity;
      stage.pixel_nibble   <= pixel_nibble;
    end
  end

  lfc_core #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .SKIP_PERIOD (SKIP_PERIOD)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .sample        (stage),
    .result_present(core_present),
    .result        (core_result)
  );

  lfc_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .load_present(core_present),
    .load_data   (core_result),
    .free        (out_free),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (out_data)
  );

  assign write_valid  = out_data.write_valid;
  assign write_field  = out_data.write_field;
  assign write_row    = out_data.write_row;
  assign write_column = out_data.write_column;
  assign write_pixels = out_data.write_pixels;
  assign frame_done   = out_data.frame_done;

endmodule

FILE: dv/tb_lcd_field_capture.sv
// Self-checking testbench for lcd_field_capture: drives bus samples and restarts,
// predicts the framebuffer writes and frame-done markers, and checks each result.
// Depends on lfc_pkg and the lcd_field_capture RTL.
module tb_lcd_field_capture;
  timeunit 1ns;
  timeprecision 1ps;

  import lfc_pkg::*;

  localparam int FRAME_WIDTH  = 160;
  localparam int FRAME_HEIGHT = 144;
  localparam int SKIP_PERIOD  = 10;
  localparam int STIM_TARGET  = 1600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int NO_ABORT     = 4;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic {
    STIM_SAMPLE = 1'b0,
    STIM_DRAIN  = 1'b1
  } stim_kind_t;

  typedef struct {
    stim_kind_t kind;
    sample_t    s;
  } bus_item_t;

  logic       clk;
  logic       rst            = 1'b1;
  logic       sample_valid   = 1'b0;
  logic       sample_ready;
  logic       operation      = 1'b0;
  logic       pixel_clock    = 1'b0;
  logic       line_latch     = 1'b0;
  logic       frame_polarity = 1'b0;
  logic [3:0] pixel_nibble   = 4'd0;
  logic       result_valid;
  logic       result_ready   = 1'b0;
  logic       write_valid;
  logic       write_field;
  logic [7:0] write_row;
  logic [7:0] write_column;
  logic [3:0] write_pixels;
  logic       frame_done;

  lcd_field_capture #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .SKIP_PERIOD (SKIP_PERIOD)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .operation     (operation),
    .pixel_clock   (pixel_clock),
    .line_latch    (line_latch),
    .frame_polarity(frame_polarity),
    .pixel_nibble  (pixel_nibble),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .write_valid   (write_valid),
    .write_field   (write_field),
    .write_row     (write_row),
    .write_column  (write_column),
    .write_pixels  (write_pixels),
    .frame_done    (frame_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  bus_item_t bus_samples[$];
  result_t   pending_results[$];
  int        n_stim;
  int        n_total;
  int        n_accepted;
  int        n_results;
  int        n_faults;
  int        cycle_count;

  // Capture state as the block should hold it
  logic       cap_waiting;
  logic       cap_prev_clk;
  logic       cap_prev_lat;
  logic       cap_prev_pol;
  logic       cap_skipping;
  logic       cap_finished;
  logic [2:0] cap_field;
  logic [7:0] cap_row;
  logic [7:0] cap_col;

  // Pin levels last queued by the stimulus generator
  logic g_lat;
  logic g_pol;

  task automatic rearm_capture();
    cap_waiting  = 1'b1;
    cap_prev_clk = 1'b0;
    cap_prev_lat = 1'b0;
    cap_prev_pol = 1'b1;
    cap_skipping = 1'b0;
    cap_finished = 1'b0;
    cap_field    = '0;
    cap_row      = '0;
    cap_col      = '0;
  endtask

  task automatic capture_sample(input sample_t s);
    result_t r;
    logic    hit;
    r   = '0;
    hit = 1'b0;
    if (s.op == OP_RESTART) begin
      rearm_capture();
      return;
    end
    if (cap_finished) return;
    if (cap_waiting) begin
      if (!cap_prev_pol && s.frame_polarity) begin
        cap_prev_pol = 1'b1;
        cap_waiting  = 1'b0;
      end else begin
        cap_prev_clk = s.pixel_clock;
        cap_prev_lat = s.line_latch;
        cap_prev_pol = s.frame_polarity;
        return;
      end
    end
    // A latch edge wins over a clock edge in the same sample
    if (s.line_latch && !cap_prev_lat) begin
      if ((cap_row % SKIP_PERIOD) == 0 && !cap_skipping) begin
        cap_skipping = 1'b1;
      end else begin
        cap_skipping = 1'b0;
        if (cap_row != COUNT_MAX) cap_row = cap_row + 8'd1;
        cap_col = '0;
      end
    end else if (s.pixel_clock && !cap_prev_clk) begin
      if (cap_col < FRAME_WIDTH - 3 && !cap_skipping && cap_row < FRAME_HEIGHT &&
          cap_field < LAST_WRITTEN_FIELD_LIMIT) begin
        r.write_valid  = 1'b1;
        r.write_field  = cap_field[0];
        r.write_row    = cap_row;
        r.write_column = cap_col;
        r.write_pixels = s.pixel_nibble;
        hit            = 1'b1;
        if ({1'b0, cap_col} + COLUMN_STEP > {1'b0, COUNT_MAX}) cap_col = COUNT_MAX;
        else cap_col = cap_col + 8'(COLUMN_STEP);
      end
    end
    if (s.frame_polarity != cap_prev_pol) begin
      if (cap_field != FIELD_MAX) cap_field = cap_field + 3'd1;
      cap_row = '0;
      cap_col = '0;
      if (s.frame_polarity && cap_field > LAST_WRITTEN_FIELD_LIMIT) begin
        cap_finished = 1'b1;
        r            = '0;
        r.frame_done = 1'b1;
        hit          = 1'b1;
      end
    end
    cap_prev_clk = s.pixel_clock;
    cap_prev_lat = s.line_latch;
    cap_prev_pol = s.frame_polarity;
    if (hit) pending_results.push_back(r);
  endtask

  task automatic push_sample(input op_t op, input logic c, input logic l, input logic p,
                             input logic [3:0] nib);
    bus_item_t it;
    it.kind             = STIM_SAMPLE;
    it.s.op             = op;
    it.s.pixel_clock    = c;
    it.s.line_latch     = l;
    it.s.frame_polarity = p;
    it.s.pixel_nibble   = nib;
    bus_samples.push_back(it);
    n_stim++;
    g_lat = l;
    g_pol = p;
  endtask

  // Oversampled pins: a level sometimes shows up in two samples in a row
  task automatic add_pins(input logic c, input logic l, input logic p);
    repeat (($urandom_range(0, 3) == 0) ? 2 : 1)
      push_sample(OP_SAMPLE, c, l, p, 4'($urandom_range(0, 15)));
  endtask

  task automatic add_drain();
    bus_item_t it;
    it.kind = STIM_DRAIN;
    it.s    = '0;
    bus_samples.push_back(it);
  endtask

  task automatic clock_pulses(input int n);
    repeat (n) begin
      add_pins(1'b1, g_lat, g_pol);
      add_pins(1'b0, g_lat, g_pol);
    end
  endtask

  task automatic field_body(input int rows, input int max_clk);
    int n;
    repeat (rows) begin
      n = $urandom_range(0, max_clk);
      // Now and then a row wide enough to run past the last column
      if (max_clk > 0 && $urandom_range(0, 29) == 0) n = 42;
      clock_pulses(n);
      if ($urandom_range(0, 7) == 0) begin
        add_pins(1'b0, 1'b0, g_pol);
        add_pins(1'b1, 1'b1, g_pol);
      end else begin
        add_pins(1'b0, 1'b1, g_pol);
      end
      add_pins(1'b0, 1'b0, g_pol);
    end
  endtask

  task automatic capture_frame(input int rows0, input int rows_rest, input int max_clk,
                               input int abort_at);
    push_sample(OP_RESTART, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    repeat ($urandom_range(1, 3))
      add_pins(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    add_pins(1'($urandom_range(0, 1)), 1'b0, 1'b1);
    if (abort_at == 0) return;
    field_body(rows0, max_clk);
    clock_pulses($urandom_range(0, 2));
    add_pins(1'($urandom_range(0, 1)), 1'b0, 1'b0);
    if (abort_at == 1) return;
    field_body(rows_rest, max_clk);
    add_pins(1'b0, 1'b0, 1'b1);
    if (abort_at == 2) return;
    field_body(1, max_clk);
    add_pins(1'b0, 1'b0, 1'b0);
    if (abort_at == 3) return;
    add_pins(1'($urandom_range(0, 1)), 1'b0, 1'b1);
    // Samples after the frame is done must be ignored
    repeat ($urandom_range(0, 3))
      push_sample(OP_SAMPLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endtask

  task automatic log_fault(input string what);
    n_faults++;
    if (n_faults <= MAX_REPORTS) $display("ERROR: %s", what);
  endtask

  function automatic string describe_result(input result_t r);
    return $sformatf("valid=%0d field=%0d row=%0d col=%0d pix=%h done=%0d", r.write_valid,
                     r.write_field, r.write_row, r.write_column, r.write_pixels, r.frame_done);
  endfunction

  // Sample channel driver
  sample_t cur_sample;
  int      tx_gap;
  logic    tx_calm;

  always @(posedge clk) begin
    bus_item_t it;
    logic      next_valid;
    if (rst) begin
      sample_valid <= 1'b0;
      tx_gap  = 0;
      tx_calm = 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        capture_sample(cur_sample);
        n_accepted++;
      end
      if (!sample_valid || sample_ready) begin
        next_valid = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else begin
          // Drop a drain marker once every predicted result has been taken
          while (bus_samples.size() > 0 && bus_samples[0].kind == STIM_DRAIN &&
                 pending_results.size() == 0)
            it = bus_samples.pop_front();
          if (bus_samples.size() > 0 && bus_samples[0].kind == STIM_SAMPLE) begin
            it             = bus_samples.pop_front();
            cur_sample     = it.s;
            next_valid     = 1'b1;
            operation      <= it.s.op;
            pixel_clock    <= it.s.pixel_clock;
            line_latch     <= it.s.line_latch;
            frame_polarity <= it.s.frame_polarity;
            pixel_nibble   <= it.s.pixel_nibble;
            tx_gap = tx_calm ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
          end
        end
        sample_valid <= next_valid;
      end
    end
  end

  // Result channel monitor and checker
  int   rx_stall;
  int   rx_hold;
  logic rx_calm;

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      rx_stall = 0;
      rx_hold  = 0;
      rx_calm  = 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got = {write_valid, write_field, write_row, write_column, write_pixels, frame_done};
        n_results++;
        if (pending_results.size() == 0) begin
          log_fault($sformatf("unexpected result %0d: %s", n_results, describe_result(got)));
        end else begin
          want = pending_results.pop_front();
          if (got.write_valid !== want.write_valid || got.write_field !== want.write_field ||
              got.write_row !== want.write_row || got.write_column !== want.write_column ||
              got.write_pixels !== want.write_pixels || got.frame_done !== want.frame_done)
            log_fault($sformatf("result %0d: expected %s, got %s", n_results,
                                describe_result(want), describe_result(got)));
        end
        rx_stall = rx_calm ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        // Hold off long enough for the block to back up into the sample channel
        if (n_results == 40 || n_results == 200) rx_hold = 250;
      end else if (rx_hold > 0) begin
        rx_hold--;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      result_ready <= (rx_hold == 0 && rx_stall == 0);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lcd_field_capture regression: fail");
    $finish;
  end

  initial begin
    int abort_at;
    n_stim     = 0;
    n_accepted = 0;
    n_results  = 0;
    n_faults   = 0;
    g_lat      = 1'b0;
    g_pol      = 1'b0;
    rearm_capture();

    // Directed opening: waiting, skip latch, latch over clock, field steps, done, restart
    push_sample(OP_RESTART, 1'b1, 1'b1, 1'b1, 4'hf);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b0, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b1, 1'b0, 4'hf);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b0, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b0, 1'b1, 4'hf);
    push_sample(OP_SAMPLE,  1'b0, 1'b1, 1'b1, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b0, 1'b1, 4'h3);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b1, 4'h0);
    push_sample(OP_SAMPLE,  1'b0, 1'b1, 1'b1, 4'h0);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b1, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b1, 1'b1, 4'ha);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b1, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b0, 1'b1, 4'h5);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b1, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b0, 1'b0, 4'h9);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b0, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b0, 1'b0, 4'h6);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b1, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b0, 1'b1, 4'hc);
    push_sample(OP_SAMPLE,  1'b0, 1'b0, 1'b0, 4'h0);
    push_sample(OP_SAMPLE,  1'b1, 1'b0, 1'b1, 4'h7);
    push_sample(OP_SAMPLE,  1'b1, 1'b1, 1'b0, 4'he);
    push_sample(OP_RESTART, 1'b0, 1'b0, 1'b0, 4'h0);
    add_drain();

    // One tall field runs the row counter past the frame height into saturation
    capture_frame(285, 1, 0, NO_ABORT);
    add_drain();

    while (n_stim < STIM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(4, 24))
          push_sample(($urandom_range(0, 15) == 0) ? OP_RESTART : OP_SAMPLE,
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end else begin
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : NO_ABORT;
        capture_frame($urandom_range(1, 10), $urandom_range(1, 4), 3, abort_at);
      end
      if ($urandom_range(0, 5) == 0) add_drain();
    end
    n_total = n_stim;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total || pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (n_faults == 0 && pending_results.size() == 0) begin
      $display("lcd_field_capture regression: pass");
    end else begin
      $display("lcd_field_capture regression: fail");
    end
    $finish;
  end

endmodule

FILE: lcd_field_capture.f
+incdir+hdl
hdl/lfc_pkg.sv
hdl/lfc_core.sv
hdl/lfc_out_reg.sv
hdl/lcd_field_capture.sv
dv/tb_lcd_field_capture.sv
